// ----- sv/lds_pkg.sv -----
`default_nettype none

package lds_pkg;

  // field widths of the item and result channels
  localparam int LDS_OPER_WIDTH = 16;
  localparam int LDS_D_WIDTH    = 32;
  localparam int LDS_SOL_WIDTH  = 64;
  localparam int LDS_IDX_WIDTH  = 3;
  localparam int LDS_ST_WIDTH   = 2;

  // parameter defaults
  localparam int LDS_NUM_GENERAL = 5;
  localparam int LDS_COEF_WIDTH  = 16;

  // divider step counter, wide enough for a full-width target division
  localparam int LDS_CNT_W = $clog2(LDS_D_WIDTH + 1);

  // status codes
  localparam logic [LDS_ST_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [LDS_ST_WIDTH-1:0] ST_ZERO  = 2'd1;
  localparam logic [LDS_ST_WIDTH-1:0] ST_NODIV = 2'd2;

  typedef struct packed {
    logic                 start;
    logic [LDS_CNT_W-1:0] len;
  } div_ctl_t;

  typedef struct packed {
    logic [LDS_SOL_WIDTH-1:0]  x;
    logic [LDS_SOL_WIDTH-1:0]  y;
    logic [LDS_OPER_WIDTH-1:0] g;
    logic [LDS_IDX_WIDTH-1:0]  index;
    logic [LDS_ST_WIDTH-1:0]   status;
    logic                      last;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/lds_div.sv -----
`default_nettype none

module lds_div #(
  parameter int EW = lds_pkg::LDS_COEF_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lds_pkg::div_ctl_t               ctl,
  input  wire logic [lds_pkg::LDS_D_WIDTH-1:0] dividend,
  input  wire logic [EW-1:0]                   divisor,
  output logic                                 busy,
  output logic [lds_pkg::LDS_D_WIDTH-1:0]      quo,
  output logic [EW-1:0]                        rem
);
  import lds_pkg::*;

  logic [EW-1:0]        dvs;
  logic [LDS_CNT_W-1:0] cnt;
  logic [EW:0]          rem_sh;
  logic [EW:0]          diff;

  // restoring step: one quotient bit per cycle, msb first
  always_comb begin
    rem_sh = {rem, quo[LDS_D_WIDTH-1]};
    diff   = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (busy && cnt == LDS_CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= ctl.len;
    end else if (busy) begin
      quo <= {quo[LDS_D_WIDTH-2:0], ~diff[EW]};
      rem <= diff[EW] ? rem_sh[EW-1:0] : diff[EW-1:0];
      cnt <= cnt - LDS_CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- sv/lds_seq.sv -----
`default_nettype none

module lds_seq #(
  parameter int NUM_GENERAL = lds_pkg::LDS_NUM_GENERAL,
  parameter int COEF_WIDTH  = lds_pkg::LDS_COEF_WIDTH,
  localparam int EW = (COEF_WIDTH < lds_pkg::LDS_OPER_WIDTH) ? COEF_WIDTH
                                                             : lds_pkg::LDS_OPER_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [lds_pkg::LDS_OPER_WIDTH-1:0] operand_a,
  input  wire logic [lds_pkg::LDS_OPER_WIDTH-1:0] operand_b,
  input  wire logic signed [lds_pkg::LDS_D_WIDTH-1:0] target_d,
  output logic                                    busy,
  output lds_pkg::div_ctl_t                       div_ctl,
  output logic [lds_pkg::LDS_D_WIDTH-1:0]         div_dividend,
  output logic [EW-1:0]                           div_divisor,
  input  wire logic                               div_busy,
  input  wire logic [lds_pkg::LDS_D_WIDTH-1:0]    div_quo,
  input  wire logic [EW-1:0]                      div_rem,
  output logic                                    res_valid,
  output lds_pkg::res_t                           res,
  input  wire logic                               res_take
);
  import lds_pkg::*;

  localparam int KW = $clog2(NUM_GENERAL + 1);
  localparam int QW = LDS_D_WIDTH + 1;
  localparam int PW = QW + EW + 1;

  typedef enum logic [10:0] {
    IDLE     = 11'b00000000001,
    EUC_GO   = 11'b00000000010,
    EUC_WAIT = 11'b00000000100,
    EUC_S    = 11'b00000001000,
    EUC_T    = 11'b00000010000,
    D_GO     = 11'b00000100000,
    D_WAIT   = 11'b00001000000,
    D_X      = 11'b00010000000,
    D_Y      = 11'b00100000000,
    D_Z      = 11'b01000000000,
    EMIT     = 11'b10000000000
  } state_t;

  state_t state;

  logic [EW-1:0]            r0, r1;
  logic signed [EW:0]       s0, s1, t0, t1;
  logic signed [PW-1:0]     prod;
  logic signed [QW-1:0]     qd;
  logic                     dneg;
  logic [LDS_D_WIDTH-1:0]   dmag;
  logic signed [LDS_SOL_WIDTH-1:0] x, y;
  logic [LDS_ST_WIDTH-1:0]  st;
  logic                     zflag;
  logic [KW-1:0]            k;

  logic [EW-1:0]            a_m, b_m;
  logic signed [QW-1:0]     mul_a;
  logic signed [EW:0]       mul_b;
  logic signed [PW-1:0]     prod_w;
  logic [EW:0]              bg, ag;
  logic                     is_last;

  assign a_m = operand_a[EW-1:0];
  assign b_m = operand_b[EW-1:0];

  // the one multiplier: euclid quotient or signed target quotient times a coefficient
  always_comb begin
    if (state == D_X || state == D_Y) begin
      mul_a = qd;
    end else begin
      mul_a = $signed(QW'(div_quo[EW-1:0]));
    end
    unique case (state)
      EUC_WAIT: mul_b = s1;
      EUC_S:    mul_b = t1;
      D_X:      mul_b = s0;
      D_Y:      mul_b = t0;
      default:  mul_b = '0;
    endcase
    prod_w = mul_a * mul_b;
  end

  // final coefficients are plus or minus b/g and a/g
  assign bg = s1[EW] ? (EW+1)'(0) - s1 : s1;
  assign ag = t1[EW] ? (EW+1)'(0) - t1 : t1;

  assign is_last = zflag | (k == KW'(NUM_GENERAL));

  always_comb begin
    div_ctl.start = (state == EUC_GO) || (state == D_GO);
    if (state == D_GO) begin
      div_ctl.len  = LDS_CNT_W'(LDS_D_WIDTH);
      div_dividend = dmag;
      div_divisor  = r0;
    end else begin
      div_ctl.len  = LDS_CNT_W'(EW);
      div_dividend = {r0, {(LDS_D_WIDTH - EW){1'b0}}};
      div_divisor  = r1;
    end
  end

  assign busy       = (state != IDLE);
  assign res_valid  = (state == EMIT);
  assign res.x      = x;
  assign res.y      = y;
  assign res.g      = LDS_OPER_WIDTH'(r0);
  assign res.index  = LDS_IDX_WIDTH'(k);
  assign res.status = st;
  assign res.last   = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= (a_m == '0 || b_m == '0) ? EMIT : EUC_GO;
          end
        end
        EUC_GO:   state <= EUC_WAIT;
        EUC_WAIT: begin
          if (!div_busy) begin
            state <= EUC_S;
          end
        end
        EUC_S:    state <= EUC_T;
        EUC_T:    state <= (div_rem == '0) ? D_GO : EUC_GO;
        D_GO:     state <= D_WAIT;
        D_WAIT: begin
          if (!div_busy) begin
            state <= D_X;
          end
        end
        D_X:      state <= D_Y;
        D_Y:      state <= D_Z;
        D_Z:      state <= EMIT;
        EMIT: begin
          if (res_take && is_last) begin
            state <= IDLE;
          end
        end
        default:  state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      IDLE: begin
        if (start) begin
          s0   <= (EW+1)'(1);
          s1   <= '0;
          t0   <= '0;
          t1   <= (EW+1)'(1);
          dneg <= target_d[LDS_D_WIDTH-1];
          dmag <= target_d[LDS_D_WIDTH-1] ? LDS_D_WIDTH'(-target_d)
                                          : LDS_D_WIDTH'(target_d);
          k    <= '0;
          if (a_m == '0 || b_m == '0) begin
            zflag <= 1'b1;
            r0    <= a_m | b_m;
            x     <= '0;
            y     <= '0;
            st    <= ST_ZERO;
          end else begin
            zflag <= 1'b0;
            r0    <= a_m;
            r1    <= b_m;
          end
        end
      end
      EUC_WAIT: begin
        if (!div_busy) begin
          prod <= prod_w;
        end
      end
      EUC_S: begin
        s0   <= s1;
        s1   <= s0 - prod[EW:0];
        prod <= prod_w;
      end
      EUC_T: begin
        t0 <= t1;
        t1 <= t0 - prod[EW:0];
        r0 <= r1;
        r1 <= div_rem;
      end
      D_WAIT: begin
        if (!div_busy) begin
          qd <= dneg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
          st <= (div_rem != '0) ? ST_NODIV : ST_OK;
        end
      end
      D_X: prod <= prod_w;
      D_Y: begin
        x    <= LDS_SOL_WIDTH'(prod);
        prod <= prod_w;
      end
      D_Z: y <= LDS_SOL_WIDTH'(prod);
      EMIT: begin
        if (res_take && !is_last) begin
          k <= k + KW'(1);
          x <= x + LDS_SOL_WIDTH'(bg);
          y <= y - LDS_SOL_WIDTH'(ag);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/linear_diophantine_solver.sv -----
// Solves a*x + b*y = d for one request at a time. A request carries unsigned a and b (only
// the low COEF_WIDTH bits count) and a signed 32-bit d. The block runs the extended Euclidean
// algorithm to find g = gcd(a,b) and Bezout coefficients s, t, then sends a run of
// NUM_GENERAL+1 results: index 0 is the particular solution x0 = (d/g)*s, y0 = (d/g)*t with
// d/g truncated toward zero, and index k is x0 + k*(b/g), y0 - k*(a/g); last marks the final
// result of the run. If a or b is zero a single result comes back with status 1, zero x and y,
// and g set to the nonzero operand. If g does not divide d the full run still comes back,
// every result with status 2. in_stall stays high from the accepted request until its last
// result has been handed to the output register. Each Euclid step runs the shared radix-2
// divider and uses the one shared multiplier twice; 16-bit operands need at most 23 steps.
// The divider then divides the magnitude of d by g, the multiplier forms the particular
// solution, and the results go out one after another as the output register takes each one;
// a request with a zero operand goes straight to its single result.
`default_nettype none

module linear_diophantine_solver #(
  parameter int NUM_GENERAL = lds_pkg::LDS_NUM_GENERAL,
  parameter int COEF_WIDTH  = lds_pkg::LDS_COEF_WIDTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // request channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [lds_pkg::LDS_OPER_WIDTH-1:0]     operand_a,
  input  wire logic [lds_pkg::LDS_OPER_WIDTH-1:0]     operand_b,
  input  wire logic signed [lds_pkg::LDS_D_WIDTH-1:0] target_d,
  // result channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [lds_pkg::LDS_SOL_WIDTH-1:0]    solution_x,
  output logic signed [lds_pkg::LDS_SOL_WIDTH-1:0]    solution_y,
  output logic [lds_pkg::LDS_OPER_WIDTH-1:0]          divisor_g,
  output logic [lds_pkg::LDS_IDX_WIDTH-1:0]           solution_index,
  output logic [lds_pkg::LDS_ST_WIDTH-1:0]            status,
  output logic                                        last
);
  import lds_pkg::*;

  // effective coefficient width, capped by the operand ports
  localparam int EW = (COEF_WIDTH < LDS_OPER_WIDTH) ? COEF_WIDTH : LDS_OPER_WIDTH;

  logic                   busy;
  logic                   start;
  div_ctl_t               div_ctl;
  logic [LDS_D_WIDTH-1:0] div_dividend;
  logic [EW-1:0]          div_divisor;
  logic                   div_busy;
  logic [LDS_D_WIDTH-1:0] div_quo;
  logic [EW-1:0]          div_rem;
  logic                   res_valid;
  res_t                   res;
  logic                   res_take;
  res_t                   out_q;

  // one request in flight at a time
  assign in_stall = busy;
  assign start    = in_valid & ~busy;

  // sequencer: euclid loop, target division, result run
  lds_seq #(
    .NUM_GENERAL (NUM_GENERAL),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .target_d     (target_d),
    .busy         (busy),
    .div_ctl      (div_ctl),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_busy     (div_busy),
    .div_quo      (div_quo),
    .div_rem      (div_rem),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  // shared divider, used for every euclid quotient and for d/g
  lds_div #(
    .EW (EW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // output register: refills in the same cycle the held result is taken
  assign res_take = res_valid & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign solution_x     = out_q.x;
  assign solution_y     = out_q.y;
  assign divisor_g      = out_q.g;
  assign solution_index = out_q.index;
  assign status         = out_q.status;
  assign last           = out_q.last;

endmodule

`default_nettype wire

// ----- sv/lds_checker.sv -----
`default_nettype none

module lds_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] solution_x,
  input wire logic [15:0] divisor_g,
  input wire logic [2:0]  solution_index,
  input wire logic [1:0]  status,
  input wire logic        last
);
  import lds_pkg::*;

  // nothing comes out the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(solution_x) && $stable(last)))
    else $error("stalled result changed");

  // an accepted request blocks the next one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while one is in flight");

  // a zero operand gives one lone result
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ZERO) |->
      (last && solution_index == '0 && solution_x == '0))
    else $error("zero operand result malformed");

  // every result other than a zero-operand one has a nonzero gcd
  a_gcd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_ZERO) |-> (divisor_g != '0))
    else $error("zero gcd on solved request");

endmodule

bind linear_diophantine_solver lds_checker u_lds_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .solution_x     (solution_x),
  .divisor_g      (divisor_g),
  .solution_index (solution_index),
  .status         (status),
  .last           (last)
);

`default_nettype wire
